@@ src/e2q_pkg.sv @@
// Package for the Euler angle to quaternion converter.
// Holds widths, CORDIC constants and the arctangent table; no dependencies.
package e2q_pkg;

  localparam int unsigned AngleW = 32;
  localparam int unsigned QW = 32;
  localparam int unsigned CordicStagesDef = 24;
  localparam int unsigned AngleBitsDef = 32;
  localparam int unsigned CordicW = 34;
  localparam int unsigned ZW = 33;
  localparam logic signed [CordicW-1:0] CordicStart = 34'sd652032874;
  localparam logic signed [CordicW-1:0] QOne = 34'sd1073741824;
  localparam logic signed [CordicW-1:0] QHalf = 34'sd536870912;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    unique case (idx)
      5'd0: r = 33'sd536870912;
      5'd1: r = 33'sd316933406;
      5'd2: r = 33'sd167458907;
      5'd3: r = 33'sd85004756;
      5'd4: r = 33'sd42667331;
      5'd5: r = 33'sd21354465;
      5'd6: r = 33'sd10679838;
      5'd7: r = 33'sd5340245;
      5'd8: r = 33'sd2670163;
      5'd9: r = 33'sd1335087;
      5'd10: r = 33'sd667544;
      5'd11: r = 33'sd333772;
      5'd12: r = 33'sd166886;
      5'd13: r = 33'sd83443;
      5'd14: r = 33'sd41722;
      5'd15: r = 33'sd20861;
      5'd16: r = 33'sd10430;
      5'd17: r = 33'sd5215;
      5'd18: r = 33'sd2608;
      5'd19: r = 33'sd1304;
      5'd20: r = 33'sd652;
      5'd21: r = 33'sd326;
      5'd22: r = 33'sd163;
      5'd23: r = 33'sd81;
      5'd24: r = 33'sd41;
      5'd25: r = 33'sd20;
      5'd26: r = 33'sd10;
      5'd27: r = 33'sd5;
      5'd28: r = 33'sd3;
      5'd29: r = 33'sd1;
      5'd30: r = 33'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [CordicW-1:0] clamp_one(
      input logic signed [CordicW-1:0] v);
    logic signed [CordicW-1:0] r;
    if (v > QOne) begin
      r = QOne;
    end else if (v < -QOne) begin
      r = -QOne;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ src/e2q_cordic_cell.sv @@
// One CORDIC rotation cell for three angles, registered, with valid flag.
// Depends on e2q_pkg.
module e2q_cordic_cell #(
  parameter int unsigned Stage = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  logic signed [e2q_pkg::CordicW-1:0] x_i [3],
  input  logic signed [e2q_pkg::CordicW-1:0] y_i [3],
  input  logic signed [e2q_pkg::ZW-1:0] z_i [3],
  output logic vld_o,
  output logic signed [e2q_pkg::CordicW-1:0] x_o [3],
  output logic signed [e2q_pkg::CordicW-1:0] y_o [3],
  output logic signed [e2q_pkg::ZW-1:0] z_o [3]
);

  localparam logic signed [e2q_pkg::ZW-1:0] Atan = e2q_pkg::atan_lut(5'(Stage));

  logic vld_q;
  logic signed [e2q_pkg::CordicW-1:0] x_d [3], x_q [3], y_d [3], y_q [3];
  logic signed [e2q_pkg::ZW-1:0] z_d [3], z_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!z_i[k][e2q_pkg::ZW-1]) begin
        x_d[k] = x_i[k] - (y_i[k] >>> Stage);
        y_d[k] = y_i[k] + (x_i[k] >>> Stage);
        z_d[k] = z_i[k] - Atan;
      end else begin
        x_d[k] = x_i[k] + (y_i[k] >>> Stage);
        y_d[k] = y_i[k] - (x_i[k] >>> Stage);
        z_d[k] = z_i[k] + Atan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign vld_o = vld_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

@@ src/e2q_combine.sv @@
// Forms the four quaternion components from half-angle sines and cosines.
// Three registered stages: pair products, triple products, round and clamp.
// Depends on e2q_pkg.
module e2q_combine (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  logic signed [e2q_pkg::CordicW-1:0] c_i [3],
  input  logic signed [e2q_pkg::CordicW-1:0] s_i [3],
  output logic vld_o,
  output logic signed [e2q_pkg::QW-1:0] q_o [4]
);

  // Pair products: cz*cy, sz*sy, sz*cy, cz*sy (x angle is index 0).
  logic signed [63:0] pp_d [4];
  logic signed [e2q_pkg::CordicW-1:0] pr_d [4], pr_q [4];
  logic signed [e2q_pkg::CordicW-1:0] cx_q, sx_q;
  logic signed [63:0] tp_d [8], tp_q [8];
  logic signed [64:0] sum [4];
  logic signed [34:0] rnd [4];
  logic signed [e2q_pkg::CordicW-1:0] fin [4];
  logic signed [e2q_pkg::QW-1:0] q_d [4], q_q [4];
  logic [2:0] vld_q;

  always_comb begin
    pp_d[0] = 64'(e2q_pkg::QW'(c_i[2])) * 64'(e2q_pkg::QW'(c_i[1]));
    pp_d[1] = 64'(e2q_pkg::QW'(s_i[2])) * 64'(e2q_pkg::QW'(s_i[1]));
    pp_d[2] = 64'(e2q_pkg::QW'(s_i[2])) * 64'(e2q_pkg::QW'(c_i[1]));
    pp_d[3] = 64'(e2q_pkg::QW'(c_i[2])) * 64'(e2q_pkg::QW'(s_i[1]));
    for (int k = 0; k < 4; k++) begin
      pr_d[k] = e2q_pkg::CordicW'((pp_d[k] + 64'(e2q_pkg::QHalf)) >>> 30);
    end
    tp_d[0] = 64'(e2q_pkg::QW'(pr_q[0])) * 64'(e2q_pkg::QW'(cx_q));
    tp_d[1] = 64'(e2q_pkg::QW'(pr_q[1])) * 64'(e2q_pkg::QW'(sx_q));
    tp_d[2] = 64'(e2q_pkg::QW'(pr_q[0])) * 64'(e2q_pkg::QW'(sx_q));
    tp_d[3] = 64'(e2q_pkg::QW'(pr_q[1])) * 64'(e2q_pkg::QW'(cx_q));
    tp_d[4] = 64'(e2q_pkg::QW'(pr_q[2])) * 64'(e2q_pkg::QW'(sx_q));
    tp_d[5] = 64'(e2q_pkg::QW'(pr_q[3])) * 64'(e2q_pkg::QW'(cx_q));
    tp_d[6] = 64'(e2q_pkg::QW'(pr_q[2])) * 64'(e2q_pkg::QW'(cx_q));
    tp_d[7] = 64'(e2q_pkg::QW'(pr_q[3])) * 64'(e2q_pkg::QW'(sx_q));
    sum[0] = 65'(tp_q[0]) + 65'(tp_q[1]);
    sum[1] = 65'(tp_q[2]) - 65'(tp_q[3]);
    sum[2] = 65'(tp_q[4]) + 65'(tp_q[5]);
    sum[3] = 65'(tp_q[6]) - 65'(tp_q[7]);
    for (int k = 0; k < 4; k++) begin
      rnd[k] = 35'((sum[k] + 65'(e2q_pkg::QHalf)) >>> 30);
      fin[k] = e2q_pkg::clamp_one(e2q_pkg::CordicW'(rnd[k]));
      q_d[k] = e2q_pkg::QW'(fin[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q <= pr_d;
      cx_q <= c_i[0];
      sx_q <= s_i[0];
      tp_q <= tp_d;
      q_q <= q_d;
    end
  end

  assign vld_o = vld_q[2];
  assign q_o = q_q;

endmodule

@@ src/euler_to_quaternion_top.sv @@
// Top level: ZYX Euler angles to unit quaternion over a stream interface.
// Depends on e2q_pkg, e2q_cordic_cell and e2q_combine.
//
// Channel | Direction | tdata fields, lowest bit first
// s_axis  | in        | roll_angle, pitch_angle, yaw_angle (96 bits)
// m_axis  | out       | quat_w, quat_x, quat_y, quat_z (128 bits)
//
// One word is taken per cycle unless the output stalls. Data passes
// the input register, the row of CORDIC cells, three combine stages
// and the output register. Reset clears all valid flags.
// The whole pipeline holds while a valid output word is not taken.
module euler_to_quaternion_top #(
  parameter int unsigned CORDIC_STAGES = e2q_pkg::CordicStagesDef,
  parameter int unsigned ANGLE_BITS = e2q_pkg::AngleBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [127:0] m_axis_tdata   // quat_w, quat_x, quat_y, quat_z
);

  localparam logic [e2q_pkg::AngleW-1:0] AngleMask =
      ~((e2q_pkg::AngleW)'((64'd1 << (e2q_pkg::AngleW - ANGLE_BITS)) - 64'd1));

  logic en;
  logic vld_q;
  logic signed [e2q_pkg::ZW-1:0] z0_q [3];
  logic vld_c [CORDIC_STAGES+1];
  logic signed [e2q_pkg::CordicW-1:0] xc [CORDIC_STAGES+1][3];
  logic signed [e2q_pkg::CordicW-1:0] yc [CORDIC_STAGES+1][3];
  logic signed [e2q_pkg::ZW-1:0] zc [CORDIC_STAGES+1][3];
  logic signed [e2q_pkg::CordicW-1:0] cc [3], sc [3];
  logic cmb_vld;
  logic signed [e2q_pkg::QW-1:0] q [4];

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        z0_q[k] <= e2q_pkg::ZW'(signed'(s_axis_tdata[k*32 +: 32] & AngleMask)) >>> 1;
      end
    end
  end

  assign vld_c[0] = vld_q;

  for (genvar j = 0; j < 3; j++) begin : g_lane
    assign xc[0][j] = e2q_pkg::CordicStart;
    assign yc[0][j] = '0;
    assign zc[0][j] = z0_q[j];
    assign cc[j] = e2q_pkg::clamp_one(xc[CORDIC_STAGES][j]);
    assign sc[j] = e2q_pkg::clamp_one(yc[CORDIC_STAGES][j]);
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    e2q_cordic_cell #(.Stage(g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (vld_c[g]),
      .x_i   (xc[g]),
      .y_i   (yc[g]),
      .z_i   (zc[g]),
      .vld_o (vld_c[g+1]),
      .x_o   (xc[g+1]),
      .y_o   (yc[g+1]),
      .z_o   (zc[g+1])
    );
  end

  e2q_combine u_combine (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (vld_c[CORDIC_STAGES]),
    .c_i   (cc),
    .s_i   (sc),
    .vld_o (cmb_vld),
    .q_o   (q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= cmb_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= {q[3], q[2], q[1], q[0]};
    end
  end

endmodule

@@ tb/euler_to_quaternion_top_test.sv @@
// Testbench for euler_to_quaternion_top: drives angle triples over the input stream and
// checks each quaternion word against a bit-exact CORDIC and triple-product predictor.
// Depends on e2q_pkg and the euler_to_quaternion_top RTL.
module euler_to_quaternion_top_test;

  localparam int unsigned Stages = e2q_pkg::CordicStagesDef;
  localparam int unsigned AngBits = e2q_pkg::AngleBitsDef;
  localparam int unsigned WatchLimit = 2000;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
    logic [31:0] w;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  quat_t quat_fifo[$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  euler_to_quaternion_top i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_q30(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic longint round_q30(longint v);
    return floor_shift(v + 64'sd536870912, 30);
  endfunction

  task automatic half_sincos(input logic [31:0] raw, output longint c, output longint s);
    logic [31:0] u;
    longint x, y, z, dx, dy;
    u = raw & ~((32'h1 << (32 - AngBits)) - 1);
    z = floor_shift(longint'($signed(u)), 1);
    x = 652032874;
    y = 0;
    for (int i = 0; i < Stages && i < 31; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(e2q_pkg::atan_lut(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(e2q_pkg::atan_lut(5'(i)));
      end
    end
    c = clamp_q30(x);
    s = clamp_q30(y);
  endtask

  function automatic longint tri_prod(longint a, longint b, longint c);
    return round_q30(a * b) * c;
  endfunction

  function automatic logic [31:0] finish_q30(longint sum);
    longint r;
    r = clamp_q30(round_q30(sum));
    return r[31:0];
  endfunction

  task automatic predict_quat(input logic [95:0] angles, output quat_t q);
    longint cx, sx, cy, sy, cz, sz;
    half_sincos(angles[31:0], cx, sx);
    half_sincos(angles[63:32], cy, sy);
    half_sincos(angles[95:64], cz, sz);
    q.w = finish_q30(tri_prod(cz, cy, cx) + tri_prod(sz, sy, sx));
    q.x = finish_q30(tri_prod(cz, cy, sx) - tri_prod(sz, sy, cx));
    q.y = finish_q30(tri_prod(sz, cy, sx) + tri_prod(cz, sy, cx));
    q.z = finish_q30(tri_prod(sz, cy, cx) - tri_prod(cz, sy, sx));
  endtask

  task automatic send_angles(input logic [31:0] roll, input logic [31:0] pitch,
                             input logic [31:0] yaw);
    quat_t q;
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {yaw, pitch, roll};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_quat({yaw, pitch, roll}, q);
    quat_fifo.push_back(q);
  endtask

  task automatic drain_quats();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (quat_fifo.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    quat_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (quat_fifo.size() == 0) begin
        $error("unexpected word %h", m_axis_tdata);
        errors++;
      end else begin
        want = quat_fifo.pop_front();
        if (got.w !== want.w) begin
          $error("quat_w expected %h got %h", want.w, got.w); errors++;
        end
        if (got.x !== want.x) begin
          $error("quat_x expected %h got %h", want.x, got.x); errors++;
        end
        if (got.y !== want.y) begin
          $error("quat_y expected %h got %h", want.y, got.y); errors++;
        end
        if (got.z !== want.z) begin
          $error("quat_z expected %h got %h", want.z, got.z); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("** euler_to_quaternion_top: FAILED **");
      $finish;
    end
  end

  task automatic test_extremes();
    logic [31:0] edges[6];
    edges = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h4000_0000,
              32'hc000_0000, 32'hffff_ffff};
    for (int i = 0; i < 6; i++) send_angles(edges[i], edges[i], edges[i]);
    for (int i = 0; i < 6; i++) send_angles(edges[i], edges[(i + 2) % 6], edges[(i + 4) % 6]);
    send_angles(32'h8000_0000, 32'h0, 32'h0);
    send_angles(32'h0, 32'h8000_0000, 32'h0);
    send_angles(32'h0, 32'h0, 32'h8000_0000);
    send_angles(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    send_angles(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    drain_quats();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 4 == 0) begin
        send_angles($urandom_range(0, 1) ? 32'h8000_0000 : $urandom,
                    $urandom_range(0, 1) ? 32'h7fff_ffff : $urandom, $urandom);
      end else begin
        send_angles($urandom, $urandom, $urandom);
      end
    end
    drain_quats();
  endtask

  task automatic test_back_to_back(input int count);
    calm = 1'b1;
    for (int i = 0; i < count; i++) send_angles($urandom, $urandom, $urandom);
    drain_quats();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_random(700);
    test_back_to_back(130);
    repeat (Stages + 20) @(posedge clk_i);
    if (errors == 0 && quat_fifo.size() == 0) begin
      $display("** euler_to_quaternion_top: PASSED **");
    end else begin
      $display("** euler_to_quaternion_top: FAILED **");
    end
    $finish;
  end
endmodule
